FILE: sv/gcl_pkg.sv
// shared types and constants for the gcd and lcm unit
package gcl_pkg;

	localparam int OPERAND_WIDTH_DEF = 16;
	localparam int FIELD_W           = 16;
	localparam int GCD_W             = 16;
	localparam int LCM_W             = 32;

	typedef struct packed {
		logic [FIELD_W-1:0] operand_a;
		logic [FIELD_W-1:0] operand_b;
	} in_word_t;

	typedef struct packed {
		logic [GCD_W-1:0] gcd_value;
		logic [LCM_W-1:0] lcm_value;
		logic             zero_error;
	} out_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GCD,
		ST_DIV,
		ST_MUL,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic gcd_step;
		logic div_init;
		logic div_step;
		logic mul_step;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic zero;
		logic equal;
	} dp_status_t;

endpackage

FILE: sv/gcl_ctrl.sv
// controller state machine sequencing gcd, divide and multiply phases
module gcl_ctrl #(
	parameter int OPERAND_WIDTH = gcl_pkg::OPERAND_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  gcl_pkg::dp_status_t status,
	output gcl_pkg::dp_cmd_t    cmd
);
	import gcl_pkg::*;

	localparam int CntW = $clog2(OPERAND_WIDTH);
	localparam logic [CntW-1:0] CntLast = CntW'(OPERAND_WIDTH - 1);

	state_t          state_q, state_d;
	logic [CntW-1:0] cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_GCD;
				end
			end
			ST_GCD: begin
				if (status.zero) begin
					state_d = ST_DONE;
				end else if (status.equal) begin
					cmd.div_init = 1'b1;
					cnt_d        = '0;
					state_d      = ST_DIV;
				end else begin
					cmd.gcd_step = 1'b1;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == CntLast) begin
					cnt_d   = '0;
					state_d = ST_MUL;
				end else begin
					cnt_d = cnt_q + CntW'(1);
				end
			end
			ST_MUL: begin
				cmd.mul_step = 1'b1;
				if (cnt_q == CntLast) begin
					cnt_d   = '0;
					state_d = ST_DONE;
				end else begin
					cnt_d = cnt_q + CntW'(1);
				end
			end
			ST_DONE: begin
				cmd.emit = 1'b1;
				state_d  = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted word did not make the unit busy");

	a_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> !busy)
		else $error("unit still busy after emitting a result");

endmodule

FILE: sv/gcl_datapath.sv
// datapath: binary gcd, restoring divide and shift-add multiply
module gcl_datapath #(
	parameter int OPERAND_WIDTH = gcl_pkg::OPERAND_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  gcl_pkg::in_word_t   operands,
	input  gcl_pkg::dp_cmd_t    cmd,
	output gcl_pkg::dp_status_t status,
	output gcl_pkg::out_word_t  result,
	output logic                result_valid
);
	import gcl_pkg::*;

	localparam int W  = OPERAND_WIDTH;
	localparam int KW = $clog2(OPERAND_WIDTH);

	logic [31:0]    a_ext, b_ext, g_ext;
	logic [W-1:0]   a_in, b_in;

	logic [W-1:0]   x_q, y_q, x_d, y_d;
	logic [KW-1:0]  k_q, k_d;
	logic           zero_q;
	logic [W-1:0]   g_q;
	logic [W-1:0]   rem_q;
	logic [W-1:0]   quo_q;
	logic [LCM_W-1:0] mcand_q, acc_q;
	out_word_t      result_q;
	logic           valid_q;

	logic [W:0]     rem_sh;
	logic [W+1:0]   diff;
	logic           fits;

	assign a_ext = 32'(operands.operand_a);
	assign b_ext = 32'(operands.operand_b);
	assign a_in  = a_ext[W-1:0];
	assign b_in  = b_ext[W-1:0];
	assign g_ext = 32'(g_q);

	always_comb begin
		x_d = x_q;
		y_d = y_q;
		k_d = k_q;
		if (!x_q[0] && !y_q[0]) begin
			x_d = x_q >> 1;
			y_d = y_q >> 1;
			k_d = k_q + KW'(1);
		end else if (!x_q[0]) begin
			x_d = x_q >> 1;
		end else if (!y_q[0]) begin
			y_d = y_q >> 1;
		end else if (x_q > y_q) begin
			x_d = (x_q - y_q) >> 1;
		end else begin
			y_d = (y_q - x_q) >> 1;
		end
	end

	assign rem_sh = {rem_q, quo_q[W-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, g_q};
	assign fits   = ~diff[W+1];

	assign status.zero  = zero_q;
	assign status.equal = (x_q == y_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_q  <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			valid_q <= cmd.emit;
			if (cmd.load) begin
				zero_q <= (a_in == '0) || (b_in == '0);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q     <= a_in;
			y_q     <= b_in;
			k_q     <= '0;
			quo_q   <= a_in;
			mcand_q <= LCM_W'(b_in);
		end
		if (cmd.gcd_step) begin
			x_q <= x_d;
			y_q <= y_d;
			k_q <= k_d;
		end
		if (cmd.div_init) begin
			g_q   <= x_q << k_q;
			rem_q <= '0;
			acc_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= fits ? diff[W-1:0] : rem_sh[W-1:0];
			quo_q <= {quo_q[W-2:0], fits};
		end
		if (cmd.mul_step) begin
			if (quo_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mcand_q <= mcand_q << 1;
			quo_q   <= quo_q >> 1;
		end
		if (cmd.emit) begin
			result_q.gcd_value  <= zero_q ? '0 : g_ext[GCD_W-1:0];
			result_q.lcm_value  <= zero_q ? '0 : acc_q;
			result_q.zero_error <= zero_q;
		end
	end

	assign result       = result_q;
	assign result_valid = valid_q;

	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe longer than one cycle");

	a_error_zeros: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.zero_error) |->
			(result.gcd_value == '0 && result.lcm_value == '0))
		else $error("error word carries nonzero values");

	a_gcd_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.gcd_step |-> (x_q != '0 && y_q != '0))
		else $error("gcd step on a zero operand");

endmodule

FILE: sv/gcd_lcm_unit.sv
// top level of the gcd and lcm unit
// usage:
//   drive operands and raise start; the word is taken at a rising edge with
//   start high and busy low. busy stays high until the result is emitted.
//   result_valid is high for exactly one cycle with the result word; the
//   receiver cannot stall it, so it must capture the word in that cycle.
//   a zero operand gives zero_error with gcd and lcm both zero.
// sequence, with W the operand width (16 by default):
//   binary gcd does one halving or subtract step per cycle, then a
//   restoring divide of a by the gcd forms a W-bit quotient, and a shift-add
//   multiply of that quotient by b adds at most once per quotient bit.
//   a zero operand skips the gcd, divide and multiply and goes to the result.
//   a new word may be started in the cycle the strobe is shown.
// reset:
//   arst_n clears the controller to idle and drops result_valid; no
//   result is produced for a word in flight at reset.
module gcd_lcm_unit #(
	parameter int OPERAND_WIDTH = gcl_pkg::OPERAND_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  gcl_pkg::in_word_t  operands,
	output gcl_pkg::out_word_t result,
	output logic               result_valid
);
	import gcl_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	gcl_ctrl #(
		.OPERAND_WIDTH(OPERAND_WIDTH)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.status (status),
		.cmd    (cmd)
	);

	gcl_datapath #(
		.OPERAND_WIDTH(OPERAND_WIDTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.operands     (operands),
		.cmd          (cmd),
		.status       (status),
		.result       (result),
		.result_valid (result_valid)
	);

endmodule

FILE: verif/tb.sv
// testbench for the gcd and lcm unit: directed operand table, then random pairs vs a euclid model
`timescale 1ns / 1ps

module tb;
	import gcl_pkg::*;

	localparam int OPW       = OPERAND_WIDTH_DEF;
	localparam int N_DIR     = 22;
	localparam int N_RAND    = 850;
	localparam int QUIET_LO  = 300;
	localparam int QUIET_HI  = 550;
	localparam int DRAIN_CYC = 80;

	typedef struct {
		in_word_t  w;
		bit        known;
		out_word_t exp;
	} dir_row_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      start = 1'b0;
	logic      busy;
	in_word_t  operands = '0;
	out_word_t result;
	logic      result_valid;

	out_word_t pending_results[$];
	int        mismatch_count = 0;

	dir_row_t dir_rows [N_DIR] = '{
		'{'{16'h0000, 16'h0000}, 1'b1, '{16'h0000, 32'h0000_0000, 1'b1}},
		'{'{16'h0000, 16'h0005}, 1'b1, '{16'h0000, 32'h0000_0000, 1'b1}},
		'{'{16'h0007, 16'h0000}, 1'b1, '{16'h0000, 32'h0000_0000, 1'b1}},
		'{'{16'h0000, 16'hFFFF}, 1'b1, '{16'h0000, 32'h0000_0000, 1'b1}},
		'{'{16'h0001, 16'h0001}, 1'b1, '{16'h0001, 32'h0000_0001, 1'b0}},
		'{'{16'hFFFF, 16'hFFFF}, 1'b1, '{16'hFFFF, 32'h0000_FFFF, 1'b0}},
		'{'{16'hFFFF, 16'h0001}, 1'b1, '{16'h0001, 32'h0000_FFFF, 1'b0}},
		'{'{16'h0001, 16'hFFFF}, 1'b1, '{16'h0001, 32'h0000_FFFF, 1'b0}},
		'{'{16'hFFFF, 16'hFFFE}, 1'b1, '{16'h0001, 32'hFFFD_0002, 1'b0}},
		'{'{16'h8000, 16'h8000}, 1'b1, '{16'h8000, 32'h0000_8000, 1'b0}},
		'{'{16'h8000, 16'h0001}, 1'b1, '{16'h0001, 32'h0000_8000, 1'b0}},
		'{'{16'hFFFF, 16'h8000}, 1'b1, '{16'h0001, 32'h7FFF_8000, 1'b0}},
		'{'{16'h000C, 16'h0012}, 1'b0, '0},
		'{'{16'h0030, 16'h00B4}, 1'b0, '0},
		'{'{16'h5555, 16'hAAAA}, 1'b0, '0},
		'{'{16'hAAAA, 16'h5555}, 1'b0, '0},
		'{'{16'hFFF1, 16'hFFEF}, 1'b0, '0},
		'{'{16'h0011, 16'h0013}, 1'b0, '0},
		'{'{16'h1000, 16'h0C00}, 1'b0, '0},
		'{'{16'h0001, 16'h0000}, 1'b1, '{16'h0000, 32'h0000_0000, 1'b1}},
		'{'{16'hFFFE, 16'hFFFC}, 1'b0, '0},
		'{'{16'h0D80, 16'h0990}, 1'b0, '0}
	};

	gcd_lcm_unit #(.OPERAND_WIDTH(OPW)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operands(operands),
		.result(result),
		.result_valid(result_valid)
	);

	always #1 clk = ~clk;

	function automatic out_word_t gcd_lcm_of(in_word_t w);
		longint unsigned mask;
		longint unsigned a;
		longint unsigned b;
		longint unsigned x;
		longint unsigned y;
		longint unsigned r;
		longint unsigned l;
		out_word_t       o;
		mask = (64'd1 << OPW) - 64'd1;
		a = 64'(w.operand_a) & mask;
		b = 64'(w.operand_b) & mask;
		o = '0;
		if (a == 0 || b == 0) begin
			o.zero_error = 1'b1;
			return o;
		end
		x = a;
		y = b;
		while (y != 0) begin
			r = x % y;
			x = y;
			y = r;
		end
		l = (a / x) * b;
		o.gcd_value = x[GCD_W-1:0];
		o.lcm_value = l[LCM_W-1:0];
		return o;
	endfunction

	function automatic in_word_t random_pair();
		in_word_t    w;
		int unsigned g;
		w.operand_a = 16'($urandom);
		w.operand_b = 16'($urandom);
		case ($urandom_range(9))
			4: begin
				g = $urandom_range(1, 255);
				w.operand_a = 16'(g * $urandom_range(1, 255));
				w.operand_b = 16'(g * $urandom_range(1, 255));
			end
			5: begin
				w.operand_a = 16'($urandom_range(1, 40));
				w.operand_b = 16'($urandom_range(1, 40));
			end
			6: w.operand_a = 16'(1) << $urandom_range(15);
			7: w.operand_b = w.operand_a;
			8: begin
				case ($urandom_range(2))
					0: w.operand_a = '0;
					1: w.operand_b = '0;
					default: w = '0;
				endcase
			end
			9: begin
				w.operand_a = 16'hFFFF - 16'($urandom_range(15));
				w.operand_b = 16'hFFFF - 16'($urandom_range(15));
			end
			default: ;
		endcase
		return w;
	endfunction

	// offer one word and hold it until taken
	task automatic send_word(input in_word_t w, input out_word_t exp, input bit steady);
		if (!steady && $urandom_range(99) < 11) begin
			start <= 1'b0;
			if ($urandom_range(9) == 0)
				repeat ($urandom_range(4, 70)) @(posedge clk);
			else
				repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		start    <= 1'b1;
		operands <= w;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_results.push_back(exp);
	endtask

	always @(posedge clk) begin
		out_word_t exp;
		if (arst_n && result_valid) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result word, actual %h", $time, result);
				mismatch_count++;
			end else begin
				exp = pending_results.pop_front();
				if (result.gcd_value !== exp.gcd_value) begin
					$display("%0t: gcd_value expected %h actual %h",
						$time, exp.gcd_value, result.gcd_value);
					mismatch_count++;
				end
				if (result.lcm_value !== exp.lcm_value) begin
					$display("%0t: lcm_value expected %h actual %h",
						$time, exp.lcm_value, result.lcm_value);
					mismatch_count++;
				end
				if (result.zero_error !== exp.zero_error) begin
					$display("%0t: zero_error expected %b actual %b",
						$time, exp.zero_error, result.zero_error);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		in_word_t w;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		foreach (dir_rows[i])
			send_word(dir_rows[i].w,
				dir_rows[i].known ? dir_rows[i].exp : gcd_lcm_of(dir_rows[i].w), 1'b0);
		for (int i = 0; i < N_RAND; i++) begin
			w = random_pair();
			send_word(w, gcd_lcm_of(w), i >= QUIET_LO && i < QUIET_HI);
		end
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
